// ----- hdl/mm_pkg.sv -----
// ---------------------------------------------------------------------------
// mm_pkg: shared types and constants for the matrix multiplier
// Register codes, fixed field widths, sequencer states and the lane
// control word handed from cell to cell.
// ---------------------------------------------------------------------------
package mm_pkg;

   // configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CFG_W      = 4;

   localparam logic [CSR_ADDR_W-1:0] REG_ROWS_A    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_INNER_DIM = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_COLS_B    = 2'd2;

   localparam logic [CFG_W-1:0] RST_ROWS_A    = 4'd4;
   localparam logic [CFG_W-1:0] RST_INNER_DIM = 4'd3;
   localparam logic [CFG_W-1:0] RST_COLS_B    = 4'd2;

   // result fields
   localparam int SUM_W    = 35;
   localparam int ROWCOL_W = 3;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_FEED,
      ST_WAIT,
      ST_EMIT
   } state_type;

   // control that travels with each A element down the cell chain
   typedef struct packed {
      logic valid;
      logic first;   // first term of a dot product
      logic last;    // final term of a dot product
   } lane_ctl_type;

endpackage

// ----- hdl/mm_ram.sv -----
// ---------------------------------------------------------------------------
// mm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module mm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/mm_cell.sv -----
// ---------------------------------------------------------------------------
// mm_cell: one column cell of the multiply chain
// Holds one column of B, multiplies the passing A element by its B entry
// and accumulates one element of a row of C. A passes on to the next cell.
// ---------------------------------------------------------------------------
module mm_cell #(
   parameter int ELEM_WIDTH = 16,
   parameter int MAX_DIM    = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // B column load
   input  logic                                 b_we,
   input  logic [$clog2(MAX_DIM)-1:0]           b_addr,
   input  logic signed [ELEM_WIDTH-1:0]         b_data,
   // lane from the previous cell
   input  logic signed [ELEM_WIDTH-1:0]         a_in,
   input  logic [$clog2(MAX_DIM)-1:0]           p_in,
   input  mm_pkg::lane_ctl_type                 ctl_in,
   // lane to the next cell
   output logic signed [ELEM_WIDTH-1:0]         a_out,
   output logic [$clog2(MAX_DIM)-1:0]           p_out,
   output mm_pkg::lane_ctl_type                 ctl_out,
   // finished dot product
   output logic [mm_pkg::SUM_W-1:0]             acc_out,
   output logic                                 done_out
);

   localparam int IDX_W  = $clog2(MAX_DIM);
   localparam int PROD_W = 2 * ELEM_WIDTH;
   localparam int EXT_W  = (PROD_W > mm_pkg::SUM_W) ? PROD_W : mm_pkg::SUM_W;

   logic signed [ELEM_WIDTH-1:0] b_col_ff [MAX_DIM];
   logic signed [ELEM_WIDTH-1:0] b_sel;
   logic signed [PROD_W-1:0]     prod_ff;
   logic signed [EXT_W-1:0]      prod_ext;
   mm_pkg::lane_ctl_type         ctl1_ff;
   logic [mm_pkg::SUM_W-1:0]     acc_ff;
   logic                         done_ff;
   logic signed [ELEM_WIDTH-1:0] a_out_ff;
   logic [IDX_W-1:0]             p_out_ff;
   mm_pkg::lane_ctl_type         ctl_out_ff;

   // B column storage, no reset
   always_ff @(posedge clock) begin
      if (b_we) begin
         b_col_ff[b_addr] <= b_data;
      end
   end

   assign b_sel = b_col_ff[p_in];

   // multiply stage and lane forwarding
   always_ff @(posedge clock) begin
      prod_ff  <= a_in * b_sel;
      a_out_ff <= a_in;
      p_out_ff <= p_in;
   end

   // wraps modulo 2^SUM_W, same as the wide sum cut to SUM_W bits
   assign prod_ext = EXT_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (ctl1_ff.valid) begin
         acc_ff <= (ctl1_ff.first ? '0 : acc_ff) + prod_ext[mm_pkg::SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff    <= '0;
         ctl_out_ff <= '0;
         done_ff    <= 1'b0;
      end else begin
         ctl1_ff    <= ctl_in;
         ctl_out_ff <= ctl_in;
         done_ff    <= ctl1_ff.valid && ctl1_ff.last;
      end
   end

   assign a_out    = a_out_ff;
   assign p_out    = p_out_ff;
   assign ctl_out  = ctl_out_ff;
   assign acc_out  = acc_ff;
   assign done_out = done_ff;

endmodule

// ----- hdl/matrix_multiply.sv -----
// ---------------------------------------------------------------------------
// matrix_multiply: integer matrix multiplier C = A * B
// Loads A then B one word at a time, then streams out all of C row-major.
// ---------------------------------------------------------------------------
// Usage: set rows_a (R), inner_dim (K) and cols_b (N) through the csr port
// while the block is idle (0 acts as 1, above MAX_DIM acts as MAX_DIM; a
// write to any of them restarts the load). Then send R*K words of A
// row-major followed by K*N words of B row-major, one word per cycle on
// req_. After the last B word the block stalls its input, computes C one
// row at a time and emits R*N result words row-major on rsp_, rsp_last
// marking the final one. For each row of C the row of A is streamed from
// the A RAM into the cell chain, the block waits until the last column
// cell finishes (chain depth plus multiply and accumulate stages), and the
// row is then emitted from the output register. A new load may begin
// while the last result word still waits in the output register.
// ---------------------------------------------------------------------------
module matrix_multiply #(
   parameter int MAX_DIM    = 8,
   parameter int ELEM_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // element input
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [ELEM_WIDTH-1:0]          req_element,
   // result output
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [mm_pkg::ROWCOL_W-1:0]           rsp_out_row,
   output logic [mm_pkg::ROWCOL_W-1:0]           rsp_out_col,
   output logic signed [mm_pkg::SUM_W-1:0]       rsp_product_sum,
   output logic                                  rsp_last,
   // configuration
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mm_pkg::CSR_ADDR_W-1:0]         csr_index,
   input  logic [mm_pkg::CFG_W-1:0]              csr_data
);

   localparam int IDX_W  = $clog2(MAX_DIM);
   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);

   // effective dimension minus one, clamped into 0..MAX_DIM-1
   function automatic logic [IDX_W-1:0] dim_last(input logic [mm_pkg::CFG_W-1:0] v);
      logic [mm_pkg::CFG_W:0] ext;
      begin
         ext = {1'b0, v};
         if (v == '0) begin
            return '0;
         end else if (ext > (mm_pkg::CFG_W+1)'(MAX_DIM)) begin
            return IDX_W'(MAX_DIM - 1);
         end else begin
            return IDX_W'(v - 1'b1);
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // config registers
   // ------------------------------------------------------------------
   logic [mm_pkg::CFG_W-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;
   logic [IDX_W-1:0]         r_last, k_last, n_last;
   logic                     csr_fire, cfg_hit;

   assign r_last = dim_last(rows_a_ff);
   assign k_last = dim_last(inner_dim_ff);
   assign n_last = dim_last(cols_b_ff);

   assign csr_fire = csr_valid && csr_ready;
   assign cfg_hit  = csr_fire && (csr_index == mm_pkg::REG_ROWS_A ||
                                  csr_index == mm_pkg::REG_INNER_DIM ||
                                  csr_index == mm_pkg::REG_COLS_B);

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= mm_pkg::RST_ROWS_A;
         inner_dim_ff <= mm_pkg::RST_INNER_DIM;
         cols_b_ff    <= mm_pkg::RST_COLS_B;
      end else if (csr_fire) begin
         if (csr_index == mm_pkg::REG_ROWS_A) begin
            rows_a_ff <= csr_data;
         end
         if (csr_index == mm_pkg::REG_INNER_DIM) begin
            inner_dim_ff <= csr_data;
         end
         if (csr_index == mm_pkg::REG_COLS_B) begin
            cols_b_ff <= csr_data;
         end
      end
   end

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   mm_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]  row_ff, row_in;     // load row / row of C
   logic [IDX_W-1:0]  col_ff, col_in;     // load col / feed term / emit col
   logic              phase_b_ff, phase_b_in;

   logic req_fire, end_a, end_b, feed_end, out_free, emit_fire;
   logic emit_row_end, emit_all_end, row_done;
   logic ram_wr_en, ram_rd_en, feed_issue, load_b_en;

   logic [MAX_DIM-1:0]       cell_done;
   logic [mm_pkg::SUM_W-1:0] cell_acc [MAX_DIM];

   assign req_fire     = req_valid && !req_stall;
   assign end_a        = !phase_b_ff && row_ff == r_last && col_ff == k_last;
   assign end_b        = phase_b_ff && row_ff == k_last && col_ff == n_last;
   assign feed_end     = col_ff == k_last;
   assign out_free     = !rsp_valid || !rsp_stall;
   assign emit_row_end = col_ff == n_last;
   assign emit_all_end = emit_row_end && row_ff == r_last;
   assign row_done     = cell_done[n_last];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mm_pkg::ST_LOAD: begin
            if (!cfg_hit && req_fire && end_b) begin
               state_in = mm_pkg::ST_FEED;
            end
         end
         mm_pkg::ST_FEED: begin
            if (feed_end) begin
               state_in = mm_pkg::ST_WAIT;
            end
         end
         mm_pkg::ST_WAIT: begin
            if (row_done) begin
               state_in = mm_pkg::ST_EMIT;
            end
         end
         mm_pkg::ST_EMIT: begin
            if (emit_fire && emit_row_end) begin
               state_in = emit_all_end ? mm_pkg::ST_LOAD : mm_pkg::ST_FEED;
            end
         end
         default: state_in = mm_pkg::ST_LOAD;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall  = 1'b1;
      csr_ready  = 1'b0;
      feed_issue = 1'b0;
      emit_fire  = 1'b0;
      unique case (state_ff)
         mm_pkg::ST_LOAD: begin
            // a register write wins; hold the input off while one is offered
            req_stall = csr_valid;
            csr_ready = 1'b1;
         end
         mm_pkg::ST_FEED: feed_issue = 1'b1;
         mm_pkg::ST_WAIT: ;
         mm_pkg::ST_EMIT: emit_fire = out_free;
         default: ;
      endcase
   end

   assign ram_wr_en = req_fire && !phase_b_ff;
   assign load_b_en = req_fire && phase_b_ff;
   assign ram_rd_en = feed_issue;

   // counters
   always_comb begin
      row_in     = row_ff;
      col_in     = col_ff;
      phase_b_in = phase_b_ff;
      unique case (state_ff)
         mm_pkg::ST_LOAD: begin
            if (cfg_hit) begin
               row_in     = '0;
               col_in     = '0;
               phase_b_in = 1'b0;
            end else if (req_fire) begin
               if (end_a || end_b) begin
                  row_in     = '0;
                  col_in     = '0;
                  phase_b_in = end_a;
               end else if (col_ff == (phase_b_ff ? n_last : k_last)) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         mm_pkg::ST_FEED: begin
            col_in = feed_end ? '0 : col_ff + 1'b1;
         end
         mm_pkg::ST_WAIT: ;
         mm_pkg::ST_EMIT: begin
            if (emit_fire) begin
               if (emit_row_end) begin
                  col_in = '0;
                  row_in = emit_all_end ? '0 : row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mm_pkg::ST_LOAD;
         row_ff     <= '0;
         col_ff     <= '0;
         phase_b_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         phase_b_ff <= phase_b_in;
      end
   end

   // ------------------------------------------------------------------
   // A store: element (i, p) lives at i*MAX_DIM + p
   // ------------------------------------------------------------------
   logic [ADDR_W-1:0]            a_addr;
   logic [ELEM_WIDTH-1:0]        a_rd_data;

   assign a_addr = ADDR_W'(row_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(col_ff);

   mm_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (DEPTH)
   ) u_a_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (a_addr),
      .wr_data (req_element),
      .rd_en   (ram_rd_en),
      .rd_addr (a_addr),
      .rd_data (a_rd_data)
   );

   // lane control is registered to line up with the registered RAM read
   mm_pkg::lane_ctl_type issue_ctl_ff;
   logic [IDX_W-1:0]     issue_p_ff;

   always_ff @(posedge clock) begin
      issue_p_ff <= col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ctl_ff <= '0;
      end else begin
         issue_ctl_ff.valid <= feed_issue;
         issue_ctl_ff.first <= col_ff == '0;
         issue_ctl_ff.last  <= feed_end;
      end
   end

   // ------------------------------------------------------------------
   // cell chain: cell j holds column j of B
   // ------------------------------------------------------------------
   logic signed [ELEM_WIDTH-1:0] lane_a   [MAX_DIM+1];
   logic [IDX_W-1:0]             lane_p   [MAX_DIM+1];
   mm_pkg::lane_ctl_type         lane_ctl [MAX_DIM+1];

   assign lane_a[0]   = a_rd_data;
   assign lane_p[0]   = issue_p_ff;
   assign lane_ctl[0] = issue_ctl_ff;

   for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
      mm_cell #(
         .ELEM_WIDTH (ELEM_WIDTH),
         .MAX_DIM    (MAX_DIM)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .b_we     (load_b_en && col_ff == IDX_W'(j)),
         .b_addr   (row_ff),
         .b_data   (req_element),
         .a_in     (lane_a[j]),
         .p_in     (lane_p[j]),
         .ctl_in   (lane_ctl[j]),
         .a_out    (lane_a[j+1]),
         .p_out    (lane_p[j+1]),
         .ctl_out  (lane_ctl[j+1]),
         .acc_out  (cell_acc[j]),
         .done_out (cell_done[j])
      );
   end

   // ------------------------------------------------------------------
   // output register
   // ------------------------------------------------------------------
   logic                       rsp_valid_ff;
   logic [mm_pkg::ROWCOL_W-1:0] rsp_row_ff, rsp_col_ff;
   logic [mm_pkg::SUM_W-1:0]   rsp_sum_ff;
   logic                       rsp_last_ff;

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_row_ff  <= mm_pkg::ROWCOL_W'(row_ff);
         rsp_col_ff  <= mm_pkg::ROWCOL_W'(col_ff);
         rsp_sum_ff  <= cell_acc[col_ff];
         rsp_last_ff <= emit_all_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= emit_fire;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_out_col     = rsp_col_ff;
   assign rsp_product_sum = rsp_sum_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTHESIS
   // load counters stay inside the current matrix
   a_load_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mm_pkg::ST_LOAD && !phase_b_ff) |-> (row_ff <= r_last && col_ff <= k_last))
      else $error("A load counter out of range");

   b_load_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mm_pkg::ST_LOAD && phase_b_ff) |-> (row_ff <= k_last && col_ff <= n_last))
      else $error("B load counter out of range");

   // nothing enters the chain while a row is being emitted
   chain_quiet_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mm_pkg::ST_EMIT) |-> !issue_ctl_ff.valid)
      else $error("cell chain busy during emit");

   // the final result word is the bottom-right corner of C
   last_is_corner: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && emit_all_end) |=> (rsp_last_ff && state_ff == mm_pkg::ST_LOAD))
      else $error("last flag does not close the result matrix");
`endif

endmodule
